// ===== hdl/rv32_subset_execute_defines.svh =====
// Assertion macros for the rv32_subset_execute RTL.
// Included by the modules that carry concurrent assertions; needs nothing else.
`ifndef RV32_SUBSET_EXECUTE_DEFINES_SVH
`define RV32_SUBSET_EXECUTE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock, off during reset.
`define RVSE_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock, off during reset.
`define RVSE_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rvse_pkg.sv =====
// Shared types and constants of the rv32_subset_execute block.
// Used by the front, queue, back and top modules; depends on nothing.
package rvse_pkg;

    localparam int REG_COUNT_DEFAULT = 32;
    localparam int QUEUE_DEPTH       = 2;
    localparam logic [31:0] START_PC_RESET = 32'h8000_0000;

    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [31:0] EBREAK_WORD = 32'b0000000_00001_00000_000_00000_1110011;

    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_SW  = 3'd2;
    localparam logic [4:0] A0_IDX = 5'd10;

    typedef enum logic [1:0] {
        ST_RUN     = 2'd0,
        ST_LOAD    = 2'd1,
        ST_EBREAK  = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        CLS_ADD,
        CLS_ADDI,
        CLS_AUIPC,
        CLS_LBU,
        CLS_STORE,
        CLS_JAL,
        CLS_JALR,
        CLS_EBREAK,
        CLS_INVALID
    } cls_t;

    typedef struct packed {
        logic        is_byte;
        cls_t        cls;
        logic [4:0]  rd;
        logic        rd_ok;
        logic [4:0]  rs1;
        logic        rs1_ok;
        logic [4:0]  rs2;
        logic        rs2_ok;
        logic [31:0] imm;
        logic [2:0]  size;
        logic [7:0]  load_byte;
    } dec_t;

endpackage

// ===== hdl/rvse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents; no package.
module rvse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end
endmodule

// ===== hdl/rvse_front.sv =====
// Front end: accepts input beats, decodes instruction words into classes,
// operand indexes and immediates, and holds one decoded item. Uses rvse_pkg.
module rvse_front #(
    parameter int REG_COUNT = rvse_pkg::REG_COUNT_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [39:0]   s_axis_tdata,
    input  logic          s_axis_tuser,
    output logic          f_valid,
    output rvse_pkg::dec_t f_data,
    input  logic          f_ready
);
    import rvse_pkg::*;

    logic        valid_reg;
    dec_t        data_reg;
    dec_t        dec_next;
    logic [31:0] w;
    logic        accept;

    assign w             = s_axis_tdata[31:0];
    assign s_axis_tready = !valid_reg || f_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign f_valid       = valid_reg;
    assign f_data        = data_reg;

    always_comb begin
        dec_next.is_byte   = s_axis_tuser;
        dec_next.load_byte = s_axis_tdata[39:32];
        dec_next.rd        = w[11:7];
        dec_next.rs1       = w[19:15];
        dec_next.rs2       = w[24:20];
        dec_next.rd_ok     = (w[11:7] != 5'd0) && (int'(w[11:7]) < REG_COUNT);
        dec_next.rs1_ok    = (w[19:15] != 5'd0) && (int'(w[19:15]) < REG_COUNT);
        dec_next.rs2_ok    = (w[24:20] != 5'd0) && (int'(w[24:20]) < REG_COUNT);
        dec_next.imm       = {{20{w[31]}}, w[31:20]};
        dec_next.size      = 3'd0;
        dec_next.cls       = CLS_INVALID;
        case (w[6:0])
            OP_REG: begin
                if (w[14:12] == F3_ADD && w[31:25] == 7'd0) begin
                    dec_next.cls = CLS_ADD;
                end
            end
            OP_IMM: begin
                if (w[14:12] == F3_ADD) begin
                    dec_next.cls = CLS_ADDI;
                end
            end
            OP_AUIPC: begin
                dec_next.cls = CLS_AUIPC;
                dec_next.imm = {w[31:12], 12'd0};
            end
            OP_LOAD: begin
                if (w[14:12] == F3_LBU) begin
                    dec_next.cls  = CLS_LBU;
                    dec_next.size = 3'd1;
                end
            end
            OP_STORE: begin
                if (w[14:12] <= F3_SW) begin
                    dec_next.cls  = CLS_STORE;
                    dec_next.size = 3'd1 << w[13:12];
                    dec_next.imm  = {{20{w[31]}}, w[31:25], w[11:7]};
                end
            end
            OP_JAL: begin
                dec_next.cls = CLS_JAL;
                dec_next.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
            OP_JALR: begin
                if (w[14:12] == F3_ADD) begin
                    dec_next.cls = CLS_JALR;
                end
            end
            default: begin
                if (w == EBREAK_WORD) begin
                    dec_next.cls = CLS_EBREAK;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (f_ready) begin
            valid_reg <= 1'b0;
        end
        if (accept) begin
            data_reg <= dec_next;
        end
    end
endmodule

// ===== hdl/rvse_queue.sv =====
// Short FIFO of decoded items between the front and the back.
// Depth from rvse_pkg::QUEUE_DEPTH; uses rvse_pkg types.
module rvse_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  rvse_pkg::dec_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output rvse_pkg::dec_t out_data
);
    import rvse_pkg::*;

    localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    dec_t            mem_reg [QUEUE_DEPTH];
    logic [PTRW-1:0] rd_ptr_reg;
    logic [PTRW-1:0] wr_ptr_reg;
    logic [CNTW-1:0] count_reg;
    logic            push;
    logic            pop;

    assign in_ready  = count_reg != CNTW'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end
endmodule

// ===== hdl/rvse_back.sv =====
// Back end: register file, pc and load state; executes one decoded item per
// beat into the output register. Uses rvse_pkg, rvse_ram and the assertion macros.
`include "rv32_subset_execute_defines.svh"
module rvse_back #(
    parameter int REG_COUNT = rvse_pkg::REG_COUNT_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [31:0]    cfg_wr_data,
    input  logic           q_valid,
    output logic           q_ready,
    input  rvse_pkg::dec_t q_data,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [167:0]   m_axis_tdata
);
    import rvse_pkg::*;

    localparam int IDXW = $clog2(REG_COUNT);

    logic [31:0]          pc_reg;
    logic                 pend_reg;
    logic [4:0]           tgt_reg;
    logic                 tgt_ok_reg;
    status_t              halted_reg;
    logic [31:0]          a0_reg;
    logic [REG_COUNT-1:0] vld_reg;

    logic        e_valid_reg;
    dec_t        e_reg;
    logic        e_fwd1_reg;
    logic        e_fwd2_reg;
    logic        e_vld1_reg;
    logic        e_vld2_reg;
    logic [31:0] e_fwd_data_reg;

    logic         m_valid_reg;
    logic [167:0] m_data_reg;

    logic [31:0] rdata1;
    logic [31:0] rdata2;
    logic        e_fire;

    logic [31:0] pc_next;
    logic        pend_next;
    logic [4:0]  tgt_next;
    logic        tgt_ok_next;
    status_t     halted_next;
    logic        wr_en;
    logic [4:0]  wr_rd;
    logic [31:0] wr_data;
    status_t     status;
    logic [31:0] ipc;
    logic        mem_v;
    logic        mem_w;
    logic [31:0] mem_addr;
    logic [2:0]  mem_size;
    logic [31:0] mem_data;
    logic [31:0] exit_code;
    logic [31:0] op1;
    logic [31:0] op2;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic [31:0] sum;
    logic [31:0] pc4;

    assign e_fire        = e_valid_reg && (!m_valid_reg || m_axis_tready);
    assign q_ready       = !e_valid_reg || e_fire;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    rvse_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf1 (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_rd[IDXW-1:0]),
        .wdata (wr_data),
        .re    (q_valid && q_ready),
        .raddr (q_data.rs1[IDXW-1:0]),
        .rdata (rdata1)
    );

    rvse_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf2 (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_rd[IDXW-1:0]),
        .wdata (wr_data),
        .re    (q_valid && q_ready),
        .raddr (q_data.rs2[IDXW-1:0]),
        .rdata (rdata2)
    );

    always_comb begin
        op1 = !e_reg.rs1_ok ? 32'd0 : e_fwd1_reg ? e_fwd_data_reg :
              e_vld1_reg ? rdata1 : 32'd0;
        op2 = !e_reg.rs2_ok ? 32'd0 : e_fwd2_reg ? e_fwd_data_reg :
              e_vld2_reg ? rdata2 : 32'd0;
        add_a = (e_reg.cls inside {CLS_AUIPC, CLS_JAL}) ? pc_reg : op1;
        add_b = (e_reg.cls == CLS_ADD) ? op2 : e_reg.imm;
        sum   = add_a + add_b;
        pc4   = pc_reg + 32'd4;

        pc_next     = pc_reg;
        pend_next   = pend_reg;
        tgt_next    = tgt_reg;
        tgt_ok_next = tgt_ok_reg;
        halted_next = halted_reg;
        wr_en       = 1'b0;
        wr_rd       = e_reg.rd;
        wr_data     = pc4;
        status      = ST_RUN;
        ipc         = pc_reg;
        mem_v       = 1'b0;
        mem_w       = 1'b0;
        mem_addr    = 32'd0;
        mem_size    = 3'd0;
        mem_data    = 32'd0;
        exit_code   = 32'd0;

        if (halted_reg != ST_RUN) begin
            status = halted_reg;
            if (halted_reg == ST_EBREAK) begin
                exit_code = a0_reg;
            end
        end else if (e_reg.is_byte) begin
            if (pend_reg) begin
                wr_en     = tgt_ok_reg;
                wr_rd     = tgt_reg;
                wr_data   = {24'd0, e_reg.load_byte};
                pend_next = 1'b0;
                ipc       = pc_reg - 32'd4;
            end
        end else if (pend_reg) begin
            status = ST_LOAD;
        end else begin
            pc_next = pc4;
            case (e_reg.cls)
                CLS_ADD, CLS_ADDI, CLS_AUIPC: begin
                    wr_en   = e_reg.rd_ok;
                    wr_data = sum;
                end
                CLS_LBU: begin
                    status      = ST_LOAD;
                    mem_v       = 1'b1;
                    mem_addr    = sum;
                    mem_size    = e_reg.size;
                    pend_next   = 1'b1;
                    tgt_next    = e_reg.rd;
                    tgt_ok_next = e_reg.rd_ok;
                end
                CLS_STORE: begin
                    mem_v    = 1'b1;
                    mem_w    = 1'b1;
                    mem_addr = sum;
                    mem_size = e_reg.size;
                    mem_data = op2;
                end
                CLS_JAL: begin
                    wr_en   = e_reg.rd_ok;
                    pc_next = sum;
                end
                CLS_JALR: begin
                    wr_en   = e_reg.rd_ok;
                    pc_next = {sum[31:1], 1'b0};
                end
                CLS_EBREAK: begin
                    status      = ST_EBREAK;
                    halted_next = ST_EBREAK;
                    exit_code   = a0_reg;
                    pc_next     = pc_reg;
                end
                default: begin
                    status      = ST_INVALID;
                    halted_next = ST_INVALID;
                    pc_next     = pc_reg;
                end
            endcase
        end
        wr_en = wr_en && e_fire;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= START_PC_RESET;
            pend_reg    <= 1'b0;
            tgt_reg     <= 5'd0;
            tgt_ok_reg  <= 1'b0;
            halted_reg  <= ST_RUN;
            a0_reg      <= 32'd0;
            vld_reg     <= '0;
            e_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                pc_reg <= cfg_wr_data;
            end else if (e_fire) begin
                pc_reg <= pc_next;
            end
            if (e_fire) begin
                pend_reg   <= pend_next;
                tgt_reg    <= tgt_next;
                tgt_ok_reg <= tgt_ok_next;
                halted_reg <= halted_next;
            end
            if (wr_en) begin
                vld_reg[wr_rd[IDXW-1:0]] <= 1'b1;
                if (wr_rd == A0_IDX) begin
                    a0_reg <= wr_data;
                end
            end
            if (q_ready) begin
                e_valid_reg <= q_valid;
            end
            if (e_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (q_valid && q_ready) begin
            e_reg          <= q_data;
            e_fwd1_reg     <= wr_en && (wr_rd == q_data.rs1);
            e_fwd2_reg     <= wr_en && (wr_rd == q_data.rs2);
            e_fwd_data_reg <= wr_data;
            e_vld1_reg     <= q_data.rs1_ok && vld_reg[q_data.rs1[IDXW-1:0]];
            e_vld2_reg     <= q_data.rs2_ok && vld_reg[q_data.rs2[IDXW-1:0]];
        end
        if (e_fire) begin
            m_data_reg <= {1'b0, exit_code, mem_data, mem_size, mem_addr, mem_w, mem_v,
                           ipc, pc_next, status};
        end
    end

    `RVSE_ASSERT_NXT(a_halt_sticks, aclk, aresetn, halted_reg != ST_RUN, halted_reg == $past(halted_reg), "halt state left")
    `RVSE_ASSERT_IMP(a_pend_not_halted, aclk, aresetn, pend_reg, halted_reg == ST_RUN, "load pending while halted")
    `RVSE_ASSERT_NXT(a_mem_step, aclk, aresetn, e_fire && mem_v && !cfg_wr_en, pc_reg == $past(pc_reg) + 32'd4, "memory request did not step pc")
endmodule

// ===== hdl/rv32_subset_execute.sv =====
// Top level of the rv32_subset_execute block: front decoder, item queue and
// back end. Uses rvse_pkg, rvse_front, rvse_queue and rvse_back.
//
// Executes add, addi, auipc, lbu, sb, sh, sw, jal, jalr and ebreak at an
// internal pc. The input stream carries an instruction word (tuser = 0) or the
// byte returned for a pending lbu (tuser = 1). Each input beat gives exactly one
// result beat with status, next and current pc, an optional memory request
// and the exit code (a0) after ebreak.
// Throughput: one beat per cycle while the receiver does not stall. The path from
// input accept to result valid runs through the front decode register loaded at
// accept, the queue write, the synchronous register file read and the output
// register.
// Reset (aresetn low) gives pc 0x80000000, a zero register file (per-entry
// valid bits), no pending load and running state. cfg_wr_en loads the pc.
// When the receiver stalls, the result holds in the output register, the back
// end holds one more item, and the queue and front fill before s_axis_tready
// drops; nothing is lost or reordered.
module rv32_subset_execute #(
    parameter int REG_COUNT = rvse_pkg::REG_COUNT_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,  // instruction[31:0], load_byte[39:32]
    input  logic         s_axis_tuser,  // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [167:0] m_axis_tdata   // status[1:0], next_pc[33:2], inst_pc[65:34],
                                        // mem_valid[66], mem_write[67],
                                        // mem_address[99:68], mem_size[102:100],
                                        // mem_write_data[134:103], exit_code[166:135]
);
    import rvse_pkg::*;

    logic f_valid;
    logic f_ready;
    dec_t f_data;
    logic q_valid;
    logic q_ready;
    dec_t q_data;

    rvse_front #(.REG_COUNT(REG_COUNT)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .f_valid       (f_valid),
        .f_data        (f_data),
        .f_ready       (f_ready)
    );

    rvse_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    rvse_back #(.REG_COUNT(REG_COUNT)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_data        (q_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );
endmodule

// ===== bench/rv32_subset_execute_test.sv =====
// Self-checking bench for rv32_subset_execute: drives instruction and load byte
// beats, predicts every result beat with its own model of the register file and pc.
// Depends on rvse_pkg and the rv32_subset_execute RTL only.
module rv32_subset_execute_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rvse_pkg::*;

    localparam int REGS = REG_COUNT_DEFAULT;
    localparam logic [2:0] F3_SB = 3'd0;
    localparam logic [2:0] F3_SH = 3'd1;
    localparam logic [2:0] F3_LB = 3'd0;
    localparam logic [2:0] F3_BAD_STORE = 3'd3;
    localparam logic [6:0] F7_SUB = 7'b0100000;
    localparam logic [6:0] OP_UNUSED = 7'b1111111;
    localparam int HOLD_CYCLES = 150;

    typedef struct {
        status_t     status;
        logic [31:0] next_pc;
        logic [31:0] inst_pc;
        logic        mem_valid;
        logic        mem_write;
        logic [31:0] mem_address;
        logic [2:0]  mem_size;
        logic [31:0] mem_write_data;
        logic [31:0] exit_code;
    } retire_t;

    class retire_tracker;
        logic [31:0] regs [REGS];
        logic [31:0] start_pc;
        logic [31:0] pc;
        logic        load_pending;
        logic [4:0]  load_rd;
        status_t     halt_state;
        int          failures;
        retire_t     predicted_retires[$];

        function new();
            foreach (regs[i]) regs[i] = 32'h0;
            start_pc     = START_PC_RESET;
            pc           = START_PC_RESET;
            load_pending = 1'b0;
            load_rd      = 5'd0;
            halt_state   = ST_RUN;
            failures     = 0;
        endfunction

        function logic [31:0] read_reg(logic [4:0] idx);
            if (idx == 5'd0 || int'(idx) >= REGS) return 32'h0;
            return regs[idx];
        endfunction

        function void write_reg(logic [4:0] idx, logic [31:0] value);
            if (idx != 5'd0 && int'(idx) < REGS) regs[idx] = value;
        endfunction

        function void set_start_pc(logic [31:0] value);
            start_pc = value;
            pc       = value;
        endfunction

        function void execute_beat(logic kind, logic [31:0] w, logic [7:0] lb);
            retire_t     r;
            logic [6:0]  op;
            logic [4:0]  rd;
            logic [2:0]  f3;
            logic [31:0] rs1v, rs2v, imm_i, imm_s, imm_u, imm_j;
            r.status         = ST_RUN;
            r.next_pc        = pc;
            r.inst_pc        = pc;
            r.mem_valid      = 1'b0;
            r.mem_write      = 1'b0;
            r.mem_address    = 32'h0;
            r.mem_size       = 3'd0;
            r.mem_write_data = 32'h0;
            r.exit_code      = 32'h0;
            op    = w[6:0];
            rd    = w[11:7];
            f3    = w[14:12];
            rs1v  = read_reg(w[19:15]);
            rs2v  = read_reg(w[24:20]);
            imm_i = {{20{w[31]}}, w[31:20]};
            imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
            imm_u = {w[31:12], 12'h000};
            imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
            if (halt_state != ST_RUN) begin
                r.status = halt_state;
                if (halt_state == ST_EBREAK) r.exit_code = read_reg(A0_IDX);
            end else if (kind) begin
                if (load_pending) begin
                    write_reg(load_rd, {24'h0, lb});
                    load_pending = 1'b0;
                    r.inst_pc    = pc - 32'd4;
                end
            end else if (load_pending) begin
                r.status = ST_LOAD;
            end else begin
                r.next_pc = pc + 32'd4;
                if (op == OP_REG && f3 == F3_ADD && w[31:25] == 7'd0) begin
                    write_reg(rd, rs1v + rs2v);
                end else if (op == OP_IMM && f3 == F3_ADD) begin
                    write_reg(rd, rs1v + imm_i);
                end else if (op == OP_AUIPC) begin
                    write_reg(rd, pc + imm_u);
                end else if (op == OP_LOAD && f3 == F3_LBU) begin
                    r.status      = ST_LOAD;
                    r.mem_valid   = 1'b1;
                    r.mem_address = rs1v + imm_i;
                    r.mem_size    = 3'd1;
                    load_pending  = 1'b1;
                    load_rd       = rd;
                end else if (op == OP_STORE && f3 <= F3_SW) begin
                    r.mem_valid      = 1'b1;
                    r.mem_write      = 1'b1;
                    r.mem_address    = rs1v + imm_s;
                    r.mem_size       = 3'd1 << f3;
                    r.mem_write_data = rs2v;
                end else if (op == OP_JAL) begin
                    write_reg(rd, pc + 32'd4);
                    r.next_pc = pc + imm_j;
                end else if (op == OP_JALR && f3 == F3_ADD) begin
                    r.next_pc = (rs1v + imm_i) & ~32'd1;
                    write_reg(rd, pc + 32'd4);
                end else if (w == EBREAK_WORD) begin
                    r.status    = ST_EBREAK;
                    halt_state  = ST_EBREAK;
                    r.exit_code = read_reg(A0_IDX);
                    r.next_pc   = pc;
                end else begin
                    r.status   = ST_INVALID;
                    halt_state = ST_INVALID;
                    r.next_pc  = pc;
                end
                pc = r.next_pc;
            end
            predicted_retires.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %h, got %h", name, want, got);
                failures++;
            end
        endfunction

        function void check_retire(logic [167:0] d);
            retire_t r;
            if (predicted_retires.size() == 0) begin
                $error("result beat with no prediction waiting: %h", d);
                failures++;
                return;
            end
            r = predicted_retires.pop_front();
            compare_field("status", {30'd0, r.status}, {30'd0, d[1:0]});
            compare_field("next_pc", r.next_pc, d[33:2]);
            compare_field("inst_pc", r.inst_pc, d[65:34]);
            compare_field("mem_valid", {31'd0, r.mem_valid}, {31'd0, d[66]});
            compare_field("mem_write", {31'd0, r.mem_write}, {31'd0, d[67]});
            compare_field("mem_address", r.mem_address, d[99:68]);
            compare_field("mem_size", {29'd0, r.mem_size}, {29'd0, d[102:100]});
            compare_field("mem_write_data", r.mem_write_data, d[134:103]);
            compare_field("exit_code", r.exit_code, d[166:135]);
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [31:0]  cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;  // instruction[31:0], load_byte[39:32]
    logic         s_axis_tuser;  // kind
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [167:0] m_axis_tdata;  // status[1:0], next_pc[33:2], inst_pc[65:34],
                                 // mem_valid[66], mem_write[67], mem_address[99:68],
                                 // mem_size[102:100], mem_write_data[134:103],
                                 // exit_code[166:135]

    retire_tracker tracker = new();
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_start;

    rv32_subset_execute dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("FAIL rv32_subset_execute");
        $finish;
    end

    // Result side: check each beat, stall at random, hold off on request.
    initial begin
        int hold_left;
        int hold_seen;
        hold_left     = 0;
        hold_seen     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) tracker.check_retire(m_axis_tdata);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_seen != hold_start) begin
                hold_seen = hold_start;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    function automatic logic [31:0] enc_r(logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2);
        return {7'd0, rs2, rs1, F3_ADD, rd, OP_REG};
    endfunction

    function automatic logic [31:0] enc_i(logic [6:0] op, logic [2:0] f3, logic [4:0] rd,
                                          logic [4:0] rs1, logic [11:0] imm);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                          logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_u(logic [4:0] rd, logic [19:0] upper);
        return {upper, rd, OP_AUIPC};
    endfunction

    function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] imm);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    function automatic logic [11:0] pick_imm12();
        case ($urandom_range(0, 7))
            0: return 12'h7ff;
            1: return 12'h800;
            2: return 12'h000;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] random_instruction();
        int         sel;
        logic [4:0] rd, rs1, rs2;
        logic [11:0] imm;
        sel = $urandom_range(0, 99);
        rd  = 5'($urandom);
        rs1 = 5'($urandom);
        rs2 = 5'($urandom);
        imm = pick_imm12();
        if (sel < 18) return enc_r(rd, rs1, rs2);
        if (sel < 40) return enc_i(OP_IMM, F3_ADD, rd, rs1, imm);
        if (sel < 48) return enc_u(rd, 20'($urandom));
        if (sel < 60) return enc_i(OP_LOAD, F3_LBU, rd, rs1, imm);
        if (sel < 78) return enc_s(3'($urandom_range(0, 2)), rs1, rs2, imm);
        if (sel < 86) return enc_j(rd, {20'($urandom), 1'b0});
        return enc_i(OP_JALR, F3_ADD, rd, rs1, imm);
    endfunction

    function automatic logic [31:0] invalid_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 4))
            0: return {F7_SUB, w[24:20], w[19:15], F3_ADD, w[11:7], OP_REG};
            1: return enc_i(OP_LOAD, F3_LB, w[11:7], w[19:15], w[31:20]);
            2: return enc_s(F3_BAD_STORE, w[19:15], w[24:20], w[31:20]);
            3: return EBREAK_WORD ^ (32'd1 << $urandom_range(7, 31));
            default: return {w[31:7], OP_UNUSED};
        endcase
    endfunction

    task automatic send_beat(input logic kind, input logic [31:0] word, input logic [7:0] lb);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {lb, word};
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        tracker.execute_beat(kind, word, lb);
    endtask

    task automatic send_instr(input logic [31:0] word);
        send_beat(1'b0, word, 8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] lb);
        send_beat(1'b1, $urandom, lb);
    endtask

    task automatic send_random_item();
        if (tracker.load_pending) begin
            if ($urandom_range(0, 9) != 0) send_byte(8'($urandom));
            else send_instr(random_instruction());
        end else begin
            if ($urandom_range(0, 24) == 0) send_byte(8'($urandom));
            else send_instr(random_instruction());
        end
    endtask

    task automatic wait_drained();
        int spins;
        spins = 0;
        while (tracker.predicted_retires.size() != 0 && spins < 20000) begin
            @(posedge aclk);
            spins++;
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic load_start_pc(input logic [31:0] value);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        tracker.set_start_pc(value);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [31:0] start;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 32'h0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 40'h0;
        s_axis_tuser  = 1'b0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        hold_start    = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_instr(enc_i(OP_IMM, F3_ADD, 5'd1, 5'd0, 12'h7ff));
        send_instr(enc_i(OP_IMM, F3_ADD, 5'd2, 5'd0, 12'h800));
        send_instr(enc_r(5'd3, 5'd1, 5'd2));
        send_instr(enc_r(5'd0, 5'd1, 5'd1));
        send_instr(enc_u(5'd4, 20'hfffff));
        send_instr(enc_s(F3_SW, 5'd2, 5'd3, 12'h800));
        send_instr(enc_s(F3_SH, 5'd4, 5'd1, 12'h000));
        send_instr(enc_s(F3_SB, 5'd0, 5'd2, 12'h7ff));
        send_instr(enc_i(OP_LOAD, F3_LBU, 5'd5, 5'd1, 12'hfff));
        send_instr(enc_r(5'd6, 5'd1, 5'd1));
        send_byte(8'hff);
        send_byte(8'h00);
        send_instr(enc_i(OP_LOAD, F3_LBU, 5'd0, 5'd0, 12'h000));
        send_byte(8'haa);
        send_instr(enc_r(5'd6, 5'd5, 5'd0));
        send_instr(enc_j(5'd7, 21'h0ffffe));
        send_instr(enc_j(5'd0, 21'h100000));
        send_instr(enc_i(OP_IMM, F3_ADD, 5'd8, 5'd0, 12'h7ff));
        send_instr(enc_i(OP_JALR, F3_ADD, 5'd9, 5'd8, 12'h000));
        send_instr(enc_i(OP_JALR, F3_ADD, 5'd0, 5'd1, 12'hfff));
        send_instr(enc_i(OP_IMM, F3_ADD, 5'd10, 5'd0, 12'h800));
        send_instr(enc_r(5'd31, 5'd10, 5'd7));

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: start = 32'h0000_0000;
                1: start = 32'hffff_ffff;
                2: start = $urandom;
                3: start = START_PC_RESET;
                default: start = $urandom & ~32'd3;
            endcase
            load_start_pc(start);
            tx_idle_pct = (p == 1) ? 63 : (p == 3) ? 22 : 0;
            rx_stall_pct <= (p == 2) ? 63 : (p == 3) ? 22 : 0;
            for (int n = 0; n < 266; n++) begin
                if (p == 4 && n % 50 == 10) hold_start <= hold_start + 1;
                send_random_item();
            end
        end

        // Halt once, on ebreak or an invalid word, then feed beats the block must ignore.
        tx_idle_pct = 22;
        rx_stall_pct <= 22;
        if (tracker.load_pending) send_byte(8'($urandom));
        send_instr(enc_i(OP_IMM, F3_ADD, A0_IDX, 5'($urandom), pick_imm12()));
        if ($urandom_range(0, 1) != 0) send_instr(EBREAK_WORD);
        else send_instr(invalid_word());
        repeat (6) send_beat(1'($urandom), $urandom, 8'($urandom));
        s_axis_tvalid <= 1'b0;

        wait_drained();
        if (tracker.predicted_retires.size() != 0) begin
            $error("%0d predicted results never arrived", tracker.predicted_retires.size());
            tracker.failures++;
        end
        if (tracker.failures == 0) begin
            $display("PASS rv32_subset_execute");
        end else begin
            $display("FAIL rv32_subset_execute");
        end
        $finish;
    end
endmodule
